// ----- design/ctaphid_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctaphid_pkg
// Shared types, protocol codes and reply tables of the CTAPHID transport.
// ----------------------------------------------------------------------------
package ctaphid_pkg;

    localparam int REPORT_BYTES = 64;
    localparam int INIT_PAYLOAD = REPORT_BYTES - 7;
    localparam int CONT_PAYLOAD = REPORT_BYTES - 5;
    localparam int AUTH_REPLY_BYTES = 77;
    localparam int VER_REPLY_BYTES = 8;

    // command bytes
    localparam logic [7:0] CMD_PING  = 8'h81;
    localparam logic [7:0] CMD_MSG   = 8'h83;
    localparam logic [7:0] CMD_INIT  = 8'h86;
    localparam logic [7:0] CMD_ERROR = 8'hbf;

    // error codes
    localparam logic [7:0] ERR_INVALID_CMD = 8'h01;
    localparam logic [7:0] ERR_INVALID_LEN = 8'h03;
    localparam logic [7:0] ERR_INVALID_SEQ = 8'h04;
    localparam logic [7:0] ERR_CHANNEL_BUSY = 8'h06;

    // init reply fields
    localparam logic [7:0] INIT_RESP_LEN = 8'd17;
    localparam logic [7:0] PROTO_VERSION = 8'd2;
    localparam logic [15:0] INIT_REQ_LEN = 16'd8;

    // u2f instruction and status bytes
    localparam logic [15:0] U2F_INS_VERSION = 16'h0003;
    localparam logic [15:0] U2F_INS_AUTH    = 16'h0002;
    localparam logic [7:0]  U2F_CHECK_ONLY  = 8'h07;
    localparam logic [7:0]  SW1_ERROR       = 8'h69;
    localparam logic [7:0]  SW2_COND        = 8'h85;
    localparam logic [7:0]  SW2_WRONG_DATA  = 8'h84;
    localparam logic [7:0]  SW1_INS         = 8'h6d;
    localparam logic [7:0]  KEY_B0 = 8'hfe;
    localparam logic [7:0]  KEY_B1 = 8'hed;
    localparam logic [7:0]  KEY_B2 = 8'hfa;
    localparam logic [7:0]  KEY_B3 = 8'hce;

    typedef struct packed {
        logic       operation;
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] resp_byte;
        logic       resp_last;
        logic       led_write;
        logic       led_level;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_DECODE, ST_COPY, ST_DRAIN, ST_CHECK,
        ST_EMIT_RD, ST_EMIT_LD, ST_EMIT_WAIT
    } ctrl_state_t;

    typedef enum logic [2:0] {
        DEC_NONE, DEC_INIT, DEC_ERR, DEC_REQ_INIT, DEC_REQ_CONT
    } dec_kind_t;

    typedef enum logic [1:0] {
        FR_INIT, FR_ERR, FR_MSG, FR_CONT
    } frame_kind_t;

    typedef enum logic [1:0] {
        RM_PING, RM_VER, RM_TWO, RM_AUTH
    } reply_mode_t;

    typedef struct packed {
        logic cap_byte;
        logic decode;
        logic copy_step;
        logic run;
        logic send;
        logic emit_load;
        logic emit_next;
    } cmd_t;

    typedef struct packed {
        dec_kind_t dec_kind;
        logic      copy_done;
        logic      req_complete;
        logic      reply_pending;
        logic      emit_last;
    } sts_t;

    // u2f version reply
    function automatic logic [7:0] ver_byte(input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0: b = 8'h55;
            3'd1: b = 8'h32;
            3'd2: b = 8'h46;
            3'd3: b = 8'h5f;
            3'd4: b = 8'h56;
            3'd5: b = 8'h32;
            3'd6: b = 8'h90;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // fixed part of the authenticate reply
    function automatic logic [7:0] auth_byte(input logic [6:0] idx);
        logic [7:0] b;
        case (idx)
            7'd0:  b = 8'h01;
            7'd1:  b = 8'hde;
            7'd2:  b = 8'had;
            7'd3:  b = 8'hbe;
            7'd4:  b = 8'hef;
            7'd5:  b = 8'h30;
            7'd6:  b = 8'h44;
            7'd7:  b = 8'h02;
            7'd8:  b = 8'h20;
            7'd9:  b = 8'h80;
            7'd41: b = 8'h02;
            7'd42: b = 8'h20;
            7'd43: b = 8'h80;
            7'd75: b = 8'h90;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// ----- design/ctaphid_u2f_transport.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctaphid_u2f_transport
// CTAPHID report reassembly, INIT and error replies, PING echo and a small
// U2F responder, with fragmentation of long replies into 64-byte reports.
//
//   channel | direction | ports                        | item
//   --------+-----------+------------------------------+---------------------
//   s_      | in        | s_valid, s_ready, s_item     | report byte or tx done
//   m_      | out       | m_valid, m_ready, m_item     | response report byte
//
// Report bytes are taken one per cycle. A request report's last byte
// leads to decode, a copy of up to 59 payload bytes into the request
// store, drain and check; each of the 64 response bytes passes read, load
// and wait states for the registered store read and the output register.
// Input is held off while a report is processed or emitted; a stalled
// result holds its byte. Reset clears all control state; no store sweep.
// ----------------------------------------------------------------------------
module ctaphid_u2f_transport #(
    parameter int MSG_BYTES = 8192
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  ctaphid_pkg::in_item_t  s_item,
    output logic                   m_valid,
    input  logic                   m_ready,
    output ctaphid_pkg::out_item_t m_item
);

    ctaphid_pkg::cmd_t cmd;
    ctaphid_pkg::sts_t sts;

    // sequencer
    ctaphid_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_op    (s_item.operation),
        .s_last  (s_item.last_byte),
        .s_ready (s_ready),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .sts     (sts),
        .cmd     (cmd)
    );

    // stores and protocol state
    ctaphid_dp #(
        .MSG_BYTES (MSG_BYTES)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_item  (s_item),
        .cmd      (cmd),
        .sts      (sts),
        .out_item (m_item)
    );

endmodule

// ----- design/ctaphid_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctaphid_ctrl
// Sequencer: takes report bytes, steps decode, payload copy, request run
// and response emission through the datapath.
// ----------------------------------------------------------------------------
module ctaphid_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_op,
    input  logic              s_last,
    output logic              s_ready,
    input  logic              m_ready,
    output logic              m_valid,
    input  ctaphid_pkg::sts_t sts,
    output ctaphid_pkg::cmd_t cmd
);

    ctaphid_pkg::ctrl_state_t state_reg, state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ctaphid_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ctaphid_pkg::ST_IDLE: begin
                if (s_valid) begin
                    if (!s_op && s_last) begin
                        state_next = ctaphid_pkg::ST_DECODE;
                    end else if (s_op && sts.reply_pending) begin
                        state_next = ctaphid_pkg::ST_EMIT_RD;
                    end
                end
            end
            ctaphid_pkg::ST_DECODE: begin
                unique case (sts.dec_kind)
                    ctaphid_pkg::DEC_INIT,
                    ctaphid_pkg::DEC_ERR:      state_next = ctaphid_pkg::ST_EMIT_RD;
                    ctaphid_pkg::DEC_REQ_INIT,
                    ctaphid_pkg::DEC_REQ_CONT: state_next = ctaphid_pkg::ST_COPY;
                    default:                   state_next = ctaphid_pkg::ST_IDLE;
                endcase
            end
            ctaphid_pkg::ST_COPY: begin
                if (sts.copy_done) begin
                    state_next = ctaphid_pkg::ST_DRAIN;
                end
            end
            ctaphid_pkg::ST_DRAIN: state_next = ctaphid_pkg::ST_CHECK;
            ctaphid_pkg::ST_CHECK: begin
                state_next = sts.req_complete ? ctaphid_pkg::ST_EMIT_RD
                                              : ctaphid_pkg::ST_IDLE;
            end
            ctaphid_pkg::ST_EMIT_RD: state_next = ctaphid_pkg::ST_EMIT_LD;
            ctaphid_pkg::ST_EMIT_LD: state_next = ctaphid_pkg::ST_EMIT_WAIT;
            ctaphid_pkg::ST_EMIT_WAIT: begin
                if (m_ready) begin
                    state_next = sts.emit_last ? ctaphid_pkg::ST_IDLE
                                               : ctaphid_pkg::ST_EMIT_RD;
                end
            end
            default: state_next = ctaphid_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        m_valid = 1'b0;
        unique case (state_reg)
            ctaphid_pkg::ST_IDLE: begin
                s_ready      = 1'b1;
                cmd.cap_byte = s_valid && !s_op;
                cmd.send     = s_valid && s_op && sts.reply_pending;
            end
            ctaphid_pkg::ST_DECODE:  cmd.decode    = 1'b1;
            ctaphid_pkg::ST_COPY:    cmd.copy_step = !sts.copy_done;
            ctaphid_pkg::ST_DRAIN:   cmd           = '0;
            ctaphid_pkg::ST_CHECK:   cmd.run       = sts.req_complete;
            ctaphid_pkg::ST_EMIT_RD: cmd           = '0;
            ctaphid_pkg::ST_EMIT_LD: cmd.emit_load = 1'b1;
            ctaphid_pkg::ST_EMIT_WAIT: begin
                m_valid       = 1'b1;
                cmd.emit_next = m_ready;
            end
            default: cmd = '0;
        endcase
    end

    // checks
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input and result channels active together");

    a_report_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && sts.emit_last) |=> s_ready)
        else $error("block not idle after final report byte");

    a_copy_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.copy_step |-> !sts.copy_done)
        else $error("copy step past payload count");

    a_emit_order: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit_load |=> m_valid)
        else $error("loaded byte not offered");

endmodule

// ----- design/ctaphid_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctaphid_dp
// Datapath: report and request stores, channel and sequence state,
// reply generation and response byte formation.
// ----------------------------------------------------------------------------
module ctaphid_dp #(
    parameter int MSG_BYTES = 8192
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  ctaphid_pkg::in_item_t  in_item,
    input  ctaphid_pkg::cmd_t      cmd,
    output ctaphid_pkg::sts_t      sts,
    output ctaphid_pkg::out_item_t out_item
);

    localparam int AW = (MSG_BYTES > 1) ? $clog2(MSG_BYTES) : 1;

    // stores
    logic [7:0] rpt_mem [ctaphid_pkg::REPORT_BYTES];
    logic [7:0] req_mem [MSG_BYTES];
    logic [7:0] rpt_rdata_reg;
    logic [7:0] req_rdata_reg;
    logic [5:0] rpt_raddr;

    // header bytes of the current report
    logic [7:0] hdr_reg [7];
    logic [5:0] byte_index_reg;

    // protocol state
    logic [15:0] request_pos_reg, request_size_reg;
    logic [7:0]  request_seq_reg, active_command_reg;
    logic [31:0] active_channel_reg, channel_counter_reg;
    logic [15:0] reply_pos_reg, reply_size_reg;
    logic [7:0]  reply_seq_reg;
    ctaphid_pkg::reply_mode_t reply_mode_reg;
    logic [7:0]  two_a_reg, two_b_reg;
    logic [7:0]  auth_x_reg [4];

    // copies of request bytes 0..2 and 72..80
    logic [7:0] rq_lo_reg [3];
    logic [7:0] rq_hi_reg [9];
    logic [7:0] rqh [9];

    // copy pipeline
    logic [5:0]  copy_src_reg, copy_cnt_reg;
    logic [15:0] copy_dst_reg, wr_dst_reg;
    logic        wr_pend_reg;

    // frame being emitted
    ctaphid_pkg::frame_kind_t frame_kind_reg;
    logic [31:0] frame_cid_reg, frame_nc_reg;
    logic [7:0]  frame_b4_reg, frame_b5_reg, frame_b6_reg, frame_code_reg;
    logic [15:0] frame_base_reg;
    logic [5:0]  frame_n_reg;
    logic [2:0]  frame_off_reg;
    logic        frame_lw_reg, frame_ll_reg;
    logic [5:0]  emit_k_reg;
    ctaphid_pkg::out_item_t out_reg;

    // header decode
    logic [31:0] cid;
    logic [7:0]  cmdb;
    logic [15:0] cnt;
    ctaphid_pkg::dec_kind_t dec_kind;
    logic [7:0]  dec_code;
    logic [15:0] cont_left;
    logic [5:0]  cont_n, init_n;
    logic [31:0] cc_inc, nc_alloc;

    assign cid  = {hdr_reg[3], hdr_reg[2], hdr_reg[1], hdr_reg[0]};
    assign cmdb = hdr_reg[4];
    assign cnt  = {hdr_reg[5], hdr_reg[6]};
    assign cont_left = request_size_reg - request_pos_reg;
    assign cont_n = (cont_left < 16'(ctaphid_pkg::CONT_PAYLOAD)) ? cont_left[5:0]
                                                                 : 6'(ctaphid_pkg::CONT_PAYLOAD);
    assign init_n = (cnt < 16'(ctaphid_pkg::INIT_PAYLOAD)) ? cnt[5:0]
                                                           : 6'(ctaphid_pkg::INIT_PAYLOAD);
    assign cc_inc   = channel_counter_reg + 32'd1;
    assign nc_alloc = (cc_inc == 32'd0) ? 32'd1 : cc_inc;

    always_comb begin
        dec_kind = ctaphid_pkg::DEC_NONE;
        dec_code = ctaphid_pkg::ERR_INVALID_CMD;
        if (cmdb[7]) begin
            if (cid != 32'd0) begin
                if (cmdb == ctaphid_pkg::CMD_INIT) begin
                    if (cnt != ctaphid_pkg::INIT_REQ_LEN) begin
                        dec_kind = ctaphid_pkg::DEC_ERR;
                        dec_code = ctaphid_pkg::ERR_INVALID_LEN;
                    end else begin
                        dec_kind = ctaphid_pkg::DEC_INIT;
                    end
                end else if (cmdb == ctaphid_pkg::CMD_PING || cmdb == ctaphid_pkg::CMD_MSG) begin
                    if (active_channel_reg != 32'd0) begin
                        dec_kind = ctaphid_pkg::DEC_ERR;
                        dec_code = ctaphid_pkg::ERR_CHANNEL_BUSY;
                    end else begin
                        dec_kind = ctaphid_pkg::DEC_REQ_INIT;
                    end
                end else begin
                    dec_kind = ctaphid_pkg::DEC_ERR;
                end
            end
        end else if (active_command_reg != 8'd0 && active_channel_reg == cid) begin
            if (cmdb == request_seq_reg) begin
                dec_kind = ctaphid_pkg::DEC_REQ_CONT;
            end else begin
                dec_kind = ctaphid_pkg::DEC_ERR;
                dec_code = ctaphid_pkg::ERR_INVALID_SEQ;
            end
        end
    end

    // request bytes past the store read as zero
    always_comb begin
        for (int j = 0; j < 9; j++) begin
            rqh[j] = (72 + j < MSG_BYTES) ? rq_hi_reg[j] : 8'd0;
        end
    end

    // request run: reply selection
    logic [15:0] ci;
    logic        key;
    ctaphid_pkg::reply_mode_t run_mode;
    logic [15:0] run_size, run_pos;
    logic        run_seq0, run_lw, run_ll;
    logic [7:0]  run_a, run_b;
    logic [5:0]  run_n;

    assign ci  = {rq_lo_reg[0], rq_lo_reg[1]};
    assign key = rqh[0] == ctaphid_pkg::KEY_B0 && rqh[1] == ctaphid_pkg::KEY_B1 &&
                 rqh[2] == ctaphid_pkg::KEY_B2 && rqh[3] == ctaphid_pkg::KEY_B3;

    always_comb begin
        run_mode = reply_mode_reg;
        run_size = reply_size_reg;
        run_pos  = reply_pos_reg;
        run_seq0 = 1'b0;
        run_lw   = 1'b0;
        run_ll   = 1'b0;
        run_a    = two_a_reg;
        run_b    = two_b_reg;
        if (active_command_reg == ctaphid_pkg::CMD_PING) begin
            run_mode = ctaphid_pkg::RM_PING;
            run_size = request_size_reg;
            run_seq0 = 1'b1;
            run_pos  = (request_size_reg < 16'(ctaphid_pkg::INIT_PAYLOAD))
                       ? request_size_reg : 16'(ctaphid_pkg::INIT_PAYLOAD);
        end else if (active_command_reg == ctaphid_pkg::CMD_MSG) begin
            if (ci == ctaphid_pkg::U2F_INS_VERSION) begin
                run_mode = ctaphid_pkg::RM_VER;
                run_size = 16'(ctaphid_pkg::VER_REPLY_BYTES);
                run_pos  = 16'(ctaphid_pkg::VER_REPLY_BYTES);
            end else if (ci == ctaphid_pkg::U2F_INS_AUTH) begin
                if (rq_lo_reg[2] == ctaphid_pkg::U2F_CHECK_ONLY || !key) begin
                    run_mode = ctaphid_pkg::RM_TWO;
                    run_a    = ctaphid_pkg::SW1_ERROR;
                    run_b    = (rq_lo_reg[2] == ctaphid_pkg::U2F_CHECK_ONLY && key)
                               ? ctaphid_pkg::SW2_COND : ctaphid_pkg::SW2_WRONG_DATA;
                    run_size = 16'd2;
                    run_pos  = 16'd2;
                end else begin
                    run_mode = ctaphid_pkg::RM_AUTH;
                    run_lw   = 1'b1;
                    run_ll   = rqh[8] != 8'd0;
                    run_size = 16'(ctaphid_pkg::AUTH_REPLY_BYTES);
                    run_seq0 = 1'b1;
                    run_pos  = 16'(ctaphid_pkg::INIT_PAYLOAD);
                end
            end else begin
                run_mode = ctaphid_pkg::RM_TWO;
                run_a    = ctaphid_pkg::SW1_INS;
                run_b    = 8'h00;
                run_size = 16'd2;
                run_pos  = 16'd2;
            end
        end
    end

    assign run_n = (run_pos < 16'(ctaphid_pkg::INIT_PAYLOAD)) ? run_pos[5:0]
                                                              : 6'(ctaphid_pkg::INIT_PAYLOAD);

    // continuation send
    logic [15:0] snd_left, snd_pos;
    logic [5:0]  snd_n;

    assign snd_left = reply_size_reg - reply_pos_reg;
    assign snd_n = (snd_left < 16'(ctaphid_pkg::CONT_PAYLOAD)) ? snd_left[5:0]
                                                               : 6'(ctaphid_pkg::CONT_PAYLOAD);
    assign snd_pos = reply_pos_reg + 16'(snd_n);

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_index_reg      <= '0;
            request_pos_reg     <= '0;
            request_size_reg    <= '0;
            request_seq_reg     <= '0;
            active_command_reg  <= '0;
            active_channel_reg  <= '0;
            channel_counter_reg <= '0;
            reply_pos_reg       <= '0;
            reply_size_reg      <= '0;
            reply_seq_reg       <= '0;
            copy_cnt_reg        <= '0;
            wr_pend_reg         <= 1'b0;
            emit_k_reg          <= '0;
        end else begin
            wr_pend_reg <= cmd.copy_step;
            if (cmd.cap_byte) begin
                byte_index_reg <= in_item.last_byte ? 6'd0 : byte_index_reg + 6'd1;
            end
            if (cmd.decode) begin
                emit_k_reg <= '0;
                case (dec_kind)
                    ctaphid_pkg::DEC_INIT: begin
                        if (cid == 32'hffff_ffff) begin
                            channel_counter_reg <= nc_alloc;
                        end
                    end
                    ctaphid_pkg::DEC_REQ_INIT: begin
                        active_channel_reg <= cid;
                        active_command_reg <= cmdb;
                        request_size_reg   <= cnt;
                        request_pos_reg    <= 16'(init_n);
                        request_seq_reg    <= '0;
                        copy_cnt_reg       <= init_n;
                    end
                    ctaphid_pkg::DEC_REQ_CONT: begin
                        request_pos_reg <= request_pos_reg + 16'(cont_n);
                        if (request_seq_reg != 8'hff) begin
                            request_seq_reg <= request_seq_reg + 8'd1;
                        end
                        copy_cnt_reg <= cont_n;
                    end
                    default: ;
                endcase
            end
            if (cmd.copy_step) begin
                copy_cnt_reg <= copy_cnt_reg - 6'd1;
            end
            if (cmd.run) begin
                emit_k_reg     <= '0;
                reply_size_reg <= run_size;
                reply_pos_reg  <= run_pos;
                if (run_seq0) begin
                    reply_seq_reg <= '0;
                end
                if (run_pos == run_size) begin
                    active_command_reg <= '0;
                    active_channel_reg <= '0;
                end
            end
            if (cmd.send) begin
                emit_k_reg    <= '0;
                reply_seq_reg <= reply_seq_reg + 8'd1;
                reply_pos_reg <= snd_pos;
                if (snd_pos == reply_size_reg) begin
                    active_command_reg <= '0;
                    active_channel_reg <= '0;
                end
            end
            if (cmd.emit_next) begin
                emit_k_reg <= emit_k_reg + 6'd1;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.cap_byte && byte_index_reg < 6'd7) begin
            hdr_reg[byte_index_reg[2:0]] <= in_item.data_byte;
        end
        if (cmd.decode) begin
            frame_cid_reg  <= cid;
            frame_code_reg <= dec_code;
            frame_nc_reg   <= (cid == 32'hffff_ffff) ? nc_alloc : cid;
            frame_lw_reg   <= 1'b0;
            frame_ll_reg   <= 1'b0;
            frame_kind_reg <= (dec_kind == ctaphid_pkg::DEC_INIT) ? ctaphid_pkg::FR_INIT
                                                                  : ctaphid_pkg::FR_ERR;
            if (dec_kind == ctaphid_pkg::DEC_REQ_CONT) begin
                copy_src_reg <= 6'd5;
                copy_dst_reg <= request_pos_reg;
            end else begin
                copy_src_reg <= 6'd7;
                copy_dst_reg <= '0;
            end
        end
        if (cmd.copy_step) begin
            copy_src_reg <= copy_src_reg + 6'd1;
            copy_dst_reg <= copy_dst_reg + 16'd1;
            wr_dst_reg   <= copy_dst_reg;
        end
        // keep the request bytes that the u2f decode looks at
        if (wr_pend_reg && 32'(wr_dst_reg) < MSG_BYTES) begin
            if (wr_dst_reg < 16'd3) begin
                rq_lo_reg[wr_dst_reg[1:0]] <= rpt_rdata_reg;
            end
            if (wr_dst_reg >= 16'd72 && wr_dst_reg <= 16'd80) begin
                rq_hi_reg[4'(wr_dst_reg - 16'd72)] <= rpt_rdata_reg;
            end
        end
        if (cmd.run) begin
            reply_mode_reg <= run_mode;
            two_a_reg      <= run_a;
            two_b_reg      <= run_b;
            if (run_mode == ctaphid_pkg::RM_AUTH) begin
                for (int i = 0; i < 4; i++) begin
                    auth_x_reg[i] <= rqh[4 + i] ^ 8'hff;
                end
            end
            frame_kind_reg <= ctaphid_pkg::FR_MSG;
            frame_cid_reg  <= active_channel_reg;
            frame_b4_reg   <= active_command_reg;
            frame_b5_reg   <= run_size[15:8];
            frame_b6_reg   <= run_size[7:0];
            frame_base_reg <= '0;
            frame_n_reg    <= run_n;
            frame_off_reg  <= 3'd7;
            frame_lw_reg   <= run_lw;
            frame_ll_reg   <= run_ll;
        end
        if (cmd.send) begin
            frame_kind_reg <= ctaphid_pkg::FR_CONT;
            frame_cid_reg  <= active_channel_reg;
            frame_b4_reg   <= reply_seq_reg;
            frame_b5_reg   <= '0;
            frame_b6_reg   <= '0;
            frame_base_reg <= reply_pos_reg;
            frame_n_reg    <= snd_n;
            frame_off_reg  <= 3'd5;
            frame_lw_reg   <= 1'b0;
            frame_ll_reg   <= 1'b0;
        end
        if (cmd.emit_load) begin
            out_reg <= out_next;
        end
    end

    // report store: byte write, one registered read
    assign rpt_raddr = cmd.copy_step ? copy_src_reg : emit_k_reg;

    always_ff @(posedge aclk) begin
        if (cmd.cap_byte) begin
            rpt_mem[byte_index_reg] <= in_item.data_byte;
        end
        rpt_rdata_reg <= rpt_mem[rpt_raddr];
    end

    // response byte position within the reply
    logic [16:0] rep_idx;
    logic [5:0]  k_rel;
    logic        in_pay, in_store;

    assign k_rel    = emit_k_reg - 6'(frame_off_reg);
    assign rep_idx  = {1'b0, frame_base_reg} + 17'(k_rel);
    assign in_pay   = (emit_k_reg >= 6'(frame_off_reg)) && (k_rel < frame_n_reg);
    assign in_store = 32'(rep_idx) < MSG_BYTES;

    // request store: copy write, one registered read
    always_ff @(posedge aclk) begin
        if (wr_pend_reg && 32'(wr_dst_reg) < MSG_BYTES) begin
            req_mem[wr_dst_reg[AW-1:0]] <= rpt_rdata_reg;
        end
        req_rdata_reg <= req_mem[rep_idx[AW-1:0]];
    end

    // reply byte by reply kind
    logic [7:0] rep_byte;

    always_comb begin
        case (reply_mode_reg)
            ctaphid_pkg::RM_PING: rep_byte = in_store ? req_rdata_reg : 8'd0;
            ctaphid_pkg::RM_VER:  rep_byte = ctaphid_pkg::ver_byte(rep_idx[2:0]);
            ctaphid_pkg::RM_TWO:  rep_byte = (rep_idx == 17'd0) ? two_a_reg : two_b_reg;
            default: begin
                if (rep_idx >= 17'd10 && rep_idx <= 17'd13) begin
                    rep_byte = auth_x_reg[2'(rep_idx[1:0] - 2'd2)];
                end else begin
                    rep_byte = ctaphid_pkg::auth_byte(rep_idx[6:0]);
                end
            end
        endcase
    end

    // response report byte
    logic [7:0] frame_byte;
    ctaphid_pkg::out_item_t out_next;

    always_comb begin
        frame_byte = 8'd0;
        if (emit_k_reg < 6'd4) begin
            frame_byte = frame_cid_reg[8 * emit_k_reg[1:0] +: 8];
        end else begin
            case (frame_kind_reg)
                ctaphid_pkg::FR_INIT: begin
                    if (emit_k_reg == 6'd4) begin
                        frame_byte = ctaphid_pkg::CMD_INIT;
                    end else if (emit_k_reg == 6'd6) begin
                        frame_byte = ctaphid_pkg::INIT_RESP_LEN;
                    end else if (emit_k_reg >= 6'd7 && emit_k_reg <= 6'd14) begin
                        frame_byte = rpt_rdata_reg;
                    end else if (emit_k_reg >= 6'd15 && emit_k_reg <= 6'd18) begin
                        frame_byte = frame_nc_reg[8 * 2'(emit_k_reg[1:0] + 2'd1) +: 8];
                    end else if (emit_k_reg == 6'd19) begin
                        frame_byte = ctaphid_pkg::PROTO_VERSION;
                    end
                end
                ctaphid_pkg::FR_ERR: begin
                    if (emit_k_reg == 6'd4) begin
                        frame_byte = ctaphid_pkg::CMD_ERROR;
                    end else if (emit_k_reg == 6'd6) begin
                        frame_byte = 8'd1;
                    end else if (emit_k_reg == 6'd7) begin
                        frame_byte = frame_code_reg;
                    end
                end
                default: begin
                    if (emit_k_reg == 6'd4) begin
                        frame_byte = frame_b4_reg;
                    end else if (in_pay) begin
                        frame_byte = rep_byte;
                    end else if (emit_k_reg == 6'd5) begin
                        frame_byte = frame_b5_reg;
                    end else if (emit_k_reg == 6'd6) begin
                        frame_byte = frame_b6_reg;
                    end
                end
            endcase
        end
        out_next.resp_byte = frame_byte;
        out_next.resp_last = emit_k_reg == 6'(ctaphid_pkg::REPORT_BYTES - 1);
        out_next.led_write = frame_lw_reg;
        out_next.led_level = frame_ll_reg;
    end

    // status to the sequencer
    assign sts.dec_kind      = dec_kind;
    assign sts.copy_done     = copy_cnt_reg == 6'd0;
    assign sts.req_complete  = request_pos_reg == request_size_reg;
    assign sts.reply_pending = reply_pos_reg != reply_size_reg;
    assign sts.emit_last     = emit_k_reg == 6'(ctaphid_pkg::REPORT_BYTES - 1);
    assign out_item          = out_reg;

endmodule

// ----- tb/sv/ctaphid_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctaphid_checker
// Watches both channels of the CTAPHID transport, rebuilds the response
// reports each accepted item should cause and compares them byte by byte.
// ----------------------------------------------------------------------------
module ctaphid_checker
    import ctaphid_pkg::*;
#(
    parameter int MSG_BYTES = 8192
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    input  logic      s_ready,
    input  in_item_t  s_item,
    input  logic      m_valid,
    input  logic      m_ready,
    input  out_item_t m_item,
    output int        errors,
    output int        pending
);

    // predicted device state
    logic [7:0]  rpt_buf [REPORT_BYTES];
    logic [5:0]  rpt_idx;
    logic [7:0]  req_mem [MSG_BYTES];
    logic [7:0]  rep_mem [MSG_BYTES];
    int          req_pos, req_size, req_seq;
    logic [7:0]  cur_cmd;
    logic [31:0] cur_chan;
    logic [31:0] chan_ctr;
    int          rep_pos, rep_size;
    logic [7:0]  rep_seq;

    logic [7:0]  frame [REPORT_BYTES];
    out_item_t   resp_q [$];
    int          printed;

    initial begin
        errors   = 0;
        pending  = 0;
        printed  = 0;
        rpt_idx  = '0;
        req_pos  = 0;
        req_size = 0;
        req_seq  = 0;
        cur_cmd  = '0;
        cur_chan = '0;
        chan_ctr = '0;
        rep_pos  = 0;
        rep_size = 0;
        rep_seq  = '0;
    end

    task automatic note_error(input string msg);
        errors++;
        if (printed < 40) begin
            $display("%0t ERROR: %s", $realtime, msg);
            printed++;
        end
    endtask

    function automatic logic [7:0] req_at(input int i);
        return (i < MSG_BYTES) ? req_mem[i] : 8'h00;
    endfunction

    function automatic logic [7:0] rep_at(input int i);
        return (i < MSG_BYTES) ? rep_mem[i] : 8'h00;
    endfunction

    task automatic clear_frame(input logic [31:0] cid);
        for (int k = 0; k < REPORT_BYTES; k++) frame[k] = 8'h00;
        frame[0] = cid[7:0];
        frame[1] = cid[15:8];
        frame[2] = cid[23:16];
        frame[3] = cid[31:24];
    endtask

    task automatic queue_frame(input logic lw, input logic ll);
        out_item_t o;
        for (int k = 0; k < REPORT_BYTES; k++) begin
            o.resp_byte = frame[k];
            o.resp_last = (k == REPORT_BYTES - 1);
            o.led_write = lw;
            o.led_level = ll;
            resp_q.push_back(o);
        end
    endtask

    task automatic error_frame(input logic [7:0] code);
        clear_frame({rpt_buf[3], rpt_buf[2], rpt_buf[1], rpt_buf[0]});
        frame[4] = CMD_ERROR;
        frame[6] = 8'd1;
        frame[7] = code;
        queue_frame(1'b0, 1'b0);
    endtask

    task automatic two_byte_reply(input logic [7:0] a, input logic [7:0] b);
        rep_mem[0] = a;
        rep_mem[1] = b;
        rep_size = 2;
        rep_pos  = 2;
    endtask

    // run the completed request and build its first response report
    task automatic run_request();
        logic        lw, ll, key;
        logic [15:0] ins;
        lw = 1'b0;
        ll = 1'b0;
        if (cur_cmd == CMD_PING) begin
            for (int i = 0; i < req_size && i < MSG_BYTES; i++) rep_mem[i] = req_mem[i];
            rep_size = req_size;
            rep_seq  = '0;
            rep_pos  = (req_size < INIT_PAYLOAD) ? req_size : INIT_PAYLOAD;
        end else if (cur_cmd == CMD_MSG) begin
            ins = {req_at(0), req_at(1)};
            key = req_at(72) == KEY_B0 && req_at(73) == KEY_B1 &&
                  req_at(74) == KEY_B2 && req_at(75) == KEY_B3;
            if (ins == U2F_INS_VERSION) begin
                rep_mem[0] = "U"; rep_mem[1] = "2"; rep_mem[2] = "F"; rep_mem[3] = "_";
                rep_mem[4] = "V"; rep_mem[5] = "2"; rep_mem[6] = 8'h90; rep_mem[7] = 8'h00;
                rep_size = VER_REPLY_BYTES;
                rep_pos  = VER_REPLY_BYTES;
            end else if (ins == U2F_INS_AUTH) begin
                if (req_at(2) == U2F_CHECK_ONLY) begin
                    two_byte_reply(SW1_ERROR, key ? SW2_COND : SW2_WRONG_DATA);
                end else if (!key) begin
                    two_byte_reply(SW1_ERROR, SW2_WRONG_DATA);
                end else begin
                    lw = 1'b1;
                    ll = (req_at(80) != 8'h00);
                    for (int i = 0; i < MSG_BYTES; i++) rep_mem[i] = 8'h00;
                    rep_mem[0] = 8'h01;
                    rep_mem[1] = 8'hde; rep_mem[2] = 8'had;
                    rep_mem[3] = 8'hbe; rep_mem[4] = 8'hef;
                    rep_mem[5] = 8'h30; rep_mem[6] = 8'h44;
                    rep_mem[7] = 8'h02; rep_mem[8] = 8'h20;
                    rep_mem[9] = 8'h80;
                    for (int i = 0; i < 4; i++) rep_mem[10 + i] = req_at(76 + i) ^ 8'hff;
                    rep_mem[41] = 8'h02; rep_mem[42] = 8'h20;
                    rep_mem[43] = 8'h80;
                    rep_mem[75] = 8'h90; rep_mem[76] = 8'h00;
                    rep_size = AUTH_REPLY_BYTES;
                    rep_seq  = '0;
                    rep_pos  = INIT_PAYLOAD;
                end
            end else begin
                two_byte_reply(SW1_INS, 8'h00);
            end
        end
        clear_frame(cur_chan);
        frame[4] = cur_cmd;
        frame[5] = rep_size[15:8];
        frame[6] = rep_size[7:0];
        for (int i = 0; i < rep_pos && i < INIT_PAYLOAD; i++) frame[7 + i] = rep_at(i);
        if (rep_pos == rep_size) begin
            cur_cmd  = '0;
            cur_chan = '0;
        end
        queue_frame(lw, ll);
    endtask

    // decode one complete incoming report
    task automatic take_report();
        logic [31:0] cid, nc;
        int          cnt, left, n;
        cid = {rpt_buf[3], rpt_buf[2], rpt_buf[1], rpt_buf[0]};
        if (rpt_buf[4][7]) begin
            cnt = {rpt_buf[5], rpt_buf[6]};
            if (cid == 32'd0) return;
            if (rpt_buf[4] == CMD_INIT) begin
                if (cnt != INIT_REQ_LEN) begin
                    error_frame(ERR_INVALID_LEN);
                    return;
                end
                nc = cid;
                if (cid == 32'hffff_ffff) begin
                    chan_ctr++;
                    if (chan_ctr == 32'd0) chan_ctr++;
                    nc = chan_ctr;
                end
                clear_frame(cid);
                frame[4] = CMD_INIT;
                frame[6] = INIT_RESP_LEN;
                for (int i = 0; i < 8; i++) frame[7 + i] = rpt_buf[7 + i];
                frame[15] = nc[7:0];
                frame[16] = nc[15:8];
                frame[17] = nc[23:16];
                frame[18] = nc[31:24];
                frame[19] = PROTO_VERSION;
                queue_frame(1'b0, 1'b0);
            end else if (rpt_buf[4] == CMD_PING || rpt_buf[4] == CMD_MSG) begin
                if (cur_chan != 32'd0) begin
                    error_frame(ERR_CHANNEL_BUSY);
                    return;
                end
                cur_chan = cid;
                cur_cmd  = rpt_buf[4];
                req_size = cnt;
                req_pos  = (cnt < INIT_PAYLOAD) ? cnt : INIT_PAYLOAD;
                req_seq  = 0;
                for (int i = 0; i < req_pos; i++) req_mem[i] = rpt_buf[7 + i];
                if (req_pos == req_size) run_request();
            end else begin
                error_frame(ERR_INVALID_CMD);
            end
        end else if (cur_cmd != 8'h00 && cur_chan == cid) begin
            if (rpt_buf[4] == req_seq[7:0]) begin
                left = req_size - req_pos;
                n = (left < CONT_PAYLOAD) ? left : CONT_PAYLOAD;
                for (int i = 0; i < n; i++)
                    if (req_pos + i < MSG_BYTES) req_mem[req_pos + i] = rpt_buf[5 + i];
                req_pos = req_pos + n;
                if (req_seq != 255) req_seq++;
                if (req_pos == req_size) run_request();
            end else begin
                error_frame(ERR_INVALID_SEQ);
            end
        end
    endtask

    // continuation report of a pending reply
    task automatic next_fragment();
        int left, n;
        if (rep_pos == rep_size) return;
        left = rep_size - rep_pos;
        n = (left < CONT_PAYLOAD) ? left : CONT_PAYLOAD;
        clear_frame(cur_chan);
        frame[4] = rep_seq;
        rep_seq  = rep_seq + 8'd1;
        for (int i = 0; i < n; i++) frame[5 + i] = rep_at(rep_pos + i);
        rep_pos = rep_pos + n;
        if (rep_pos == rep_size) begin
            cur_cmd  = '0;
            cur_chan = '0;
        end
        queue_frame(1'b0, 1'b0);
    endtask

    // predict on accepted input items, compare accepted result items
    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                if (s_item.operation) begin
                    next_fragment();
                end else begin
                    rpt_buf[rpt_idx] = s_item.data_byte;
                    rpt_idx = rpt_idx + 6'd1;
                    if (s_item.last_byte) begin
                        rpt_idx = '0;
                        take_report();
                    end
                end
            end
            if (m_valid && m_ready) begin
                if (resp_q.size() == 0) begin
                    note_error($sformatf("unexpected result byte %02h", m_item.resp_byte));
                end else begin
                    want = resp_q.pop_front();
                    if (m_item.resp_byte !== want.resp_byte)
                        note_error($sformatf("resp_byte %02h, expected %02h",
                                             m_item.resp_byte, want.resp_byte));
                    if (m_item.resp_last !== want.resp_last)
                        note_error($sformatf("resp_last %b, expected %b",
                                             m_item.resp_last, want.resp_last));
                    if (m_item.led_write !== want.led_write)
                        note_error($sformatf("led_write %b, expected %b",
                                             m_item.led_write, want.led_write));
                    if (m_item.led_level !== want.led_level)
                        note_error($sformatf("led_level %b, expected %b",
                                             m_item.led_level, want.led_level));
                end
            end
            pending = resp_q.size();
        end
    end

endmodule

// ----- tb/sv/tb_ctaphid_u2f_transport.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ctaphid_u2f_transport
// Drives CTAPHID reports and transmit-done events into the transport: INIT,
// PING, U2F version and authenticate requests, error cases and noise, under
// several idling patterns; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_ctaphid_u2f_transport;
    import ctaphid_pkg::*;

    localparam int MSG_BYTES = 8192;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_item;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_item;
    int        errors;
    int        pending;

    int        send_idle_pct;
    int        recv_stall_pct;
    logic      hold_req;
    logic [7:0] rpt [REPORT_BYTES];
    logic [7:0] msg [256];
    int         phase_items;

    ctaphid_u2f_transport #(.MSG_BYTES(MSG_BYTES)) uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_item(s_item),
        .m_valid(m_valid), .m_ready(m_ready), .m_item(m_item)
    );

    ctaphid_checker #(.MSG_BYTES(MSG_BYTES)) chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_item(s_item),
        .m_valid(m_valid), .m_ready(m_ready), .m_item(m_item),
        .errors(errors), .pending(pending)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // overall time limit
    initial begin
        #20ms;
        $display("tb_ctaphid_u2f_transport: done, errors");
        $finish;
    end

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (1500) @(posedge aclk);
                hold_req = 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // one input item, with random idle cycles ahead of it
    task automatic send_item(input logic op, input logic [7:0] b, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= '{operation: op, data_byte: b, last_byte: last};
        do @(posedge aclk); while (!s_ready);
        phase_items++;
    endtask

    // bytes past 64 wrap over the start of the report store
    task automatic send_report(input int len);
        logic [7:0] b;
        for (int i = 0; i < len; i++) begin
            b = (i < REPORT_BYTES) ? rpt[i] : 8'($urandom_range(1, 255));
            send_item(1'b0, b, i == len - 1);
        end
    endtask

    task automatic fill_report(input logic [31:0] cid, input logic [7:0] b4);
        for (int i = 0; i < REPORT_BYTES; i++) rpt[i] = 8'($urandom);
        rpt[0] = cid[7:0];
        rpt[1] = cid[15:8];
        rpt[2] = cid[23:16];
        rpt[3] = cid[31:24];
        rpt[4] = b4;
    endtask

    task automatic tx_done(input int k);
        repeat (k) send_item(1'b1, 8'($urandom), 1'($urandom));
    endtask

    function automatic logic [31:0] rand_chan();
        logic [31:0] c;
        c = $urandom;
        if (c == 32'd0 || c == 32'hffff_ffff) c = 32'h0000_1234;
        return c;
    endfunction

    // request of n bytes from msg, with optional broken continuations
    task automatic send_request(input logic [31:0] cid, input logic [7:0] cmd,
                                input int n, input bit noisy, input bit rerun);
        int          pos, seq;
        logic [7:0]  bad;
        fill_report(cid, cmd);
        rpt[5] = 8'(n >> 8);
        rpt[6] = 8'(n);
        for (int i = 0; i < INIT_PAYLOAD && i < n; i++) rpt[7 + i] = msg[i];
        send_report(REPORT_BYTES);
        pos = (n < INIT_PAYLOAD) ? n : INIT_PAYLOAD;
        seq = 0;
        while (pos < n) begin
            if (noisy && $urandom_range(2) == 0) begin
                bad = 8'((seq + 1 + $urandom_range(60)) & 8'h7f);
                if (bad == 8'(seq)) bad = bad ^ 8'h01;
                fill_report(cid, bad);
                send_report(REPORT_BYTES);
            end
            if (noisy && $urandom_range(2) == 0) begin
                fill_report(rand_chan() ^ cid, 8'(seq));
                if (rpt[0] == cid[7:0]) rpt[0] = rpt[0] ^ 8'h5a;
                send_report(REPORT_BYTES);
            end
            fill_report(cid, 8'(seq));
            for (int i = 0; i < CONT_PAYLOAD && pos + i < n; i++) rpt[5 + i] = msg[pos + i];
            send_report(REPORT_BYTES);
            pos += CONT_PAYLOAD;
            seq++;
        end
        // continuation after completion, while the reply is still pending
        if (rerun && seq > 0) begin
            fill_report(cid, 8'(seq));
            send_report(REPORT_BYTES);
        end
    endtask

    function automatic int frags(input int len);
        return (len > INIT_PAYLOAD) ? (len - INIT_PAYLOAD + CONT_PAYLOAD - 1) / CONT_PAYLOAD : 0;
    endfunction

    task automatic do_ping(input int n, input bit noisy, input bit rerun, input bit busy);
        logic [31:0] cid;
        cid = rand_chan();
        for (int i = 0; i < 256; i++) msg[i] = 8'($urandom);
        send_request(cid, CMD_PING, n, noisy, rerun);
        if (busy && n > INIT_PAYLOAD) begin
            fill_report(rand_chan(), CMD_MSG);
            send_report(REPORT_BYTES);
        end
        tx_done(frags(n) + $urandom_range(1));
    endtask

    // authenticate: kind 0 = good key, 1 = bad key, 2 = check only
    task automatic do_auth(input int kind, input int n, input logic [7:0] led);
        for (int i = 0; i < 256; i++) msg[i] = 8'($urandom);
        msg[0] = U2F_INS_AUTH[15:8];
        msg[1] = U2F_INS_AUTH[7:0];
        if (kind == 2) msg[2] = U2F_CHECK_ONLY;
        else if (msg[2] == U2F_CHECK_ONLY) msg[2] = 8'h03;
        msg[72] = KEY_B0;
        msg[73] = KEY_B1;
        msg[74] = KEY_B2;
        msg[75] = KEY_B3;
        if (kind == 1) msg[72 + $urandom_range(3)] = 8'($urandom_range(0, 200));
        else if (kind == 2 && $urandom_range(1)) msg[75] = 8'h00;
        msg[80] = led;
        send_request(rand_chan(), CMD_MSG, n, 1'b0, 1'b0);
        tx_done((kind == 0) ? frags(AUTH_REPLY_BYTES) : $urandom_range(1));
    endtask

    task automatic do_msg(input logic [15:0] ins, input int n);
        for (int i = 0; i < 256; i++) msg[i] = 8'($urandom);
        msg[0] = ins[15:8];
        msg[1] = ins[7:0];
        send_request(rand_chan(), CMD_MSG, n, 1'b0, 1'b0);
    endtask

    task automatic do_init(input bit bcast, input bit bad_len, input int len);
        fill_report(bcast ? 32'hffff_ffff : rand_chan(), CMD_INIT);
        rpt[5] = 8'h00;
        rpt[6] = INIT_REQ_LEN[7:0];
        if (bad_len) begin
            rpt[5] = 8'($urandom_range(1)) ? 8'hff : 8'h00;
            rpt[6] = 8'($urandom_range(0, 7));
        end
        send_report(len);
    endtask

    task automatic do_noise();
        logic [7:0] c;
        case ($urandom_range(4))
            0: begin
                c = 8'($urandom_range(8'h80, 8'hff));
                if (c == CMD_PING || c == CMD_MSG || c == CMD_INIT) c = 8'hff;
                fill_report(rand_chan(), c);
                send_report(REPORT_BYTES);
            end
            1: begin
                fill_report(32'd0, $urandom_range(1) ? CMD_PING : CMD_MSG);
                send_report(REPORT_BYTES);
            end
            2: begin
                fill_report(rand_chan(), 8'($urandom_range(0, 127)));
                send_report(REPORT_BYTES);
            end
            3: tx_done(1 + $urandom_range(2));
            default: do_init(1'b0, 1'b0, 64 + $urandom_range(1, 4));
        endcase
    endtask

    task automatic random_txn();
        int r;
        r = $urandom_range(99);
        if (r < 15)
            do_init($urandom_range(1), $urandom_range(99) < 15, REPORT_BYTES);
        else if (r < 45)
            do_ping(($urandom_range(3) == 0) ? $urandom_range(58, 250) : $urandom_range(0, 120),
                    $urandom_range(1), $urandom_range(3) == 0, $urandom_range(3) == 0);
        else if (r < 55)
            do_msg(U2F_INS_VERSION, $urandom_range(2, 60));
        else if (r < 75)
            do_auth($urandom_range(2), $urandom_range(81, 160), 8'($urandom_range(1) * $urandom));
        else if (r < 82)
            do_msg(16'($urandom), $urandom_range(2, 120));
        else
            do_noise();
    endtask

    initial begin
        aresetn        <= 1'b0;
        s_valid        <= 1'b0;
        s_item         <= '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req       = 1'b0;
        phase_items    = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: first request writes every request byte read later
        do_auth(0, 81, 8'h01);
        do_auth(0, 90, 8'h00);
        do_auth(1, 81, 8'h01);
        do_auth(2, 81, 8'h00);
        do_msg(U2F_INS_VERSION, 2);
        do_msg(16'h00ff, 5);
        do_msg(16'hffff, 0);
        do_ping(0, 1'b0, 1'b0, 1'b0);
        do_ping(57, 1'b0, 1'b0, 1'b0);
        do_ping(250, 1'b1, 1'b1, 1'b1);
        do_init(1'b1, 1'b0, REPORT_BYTES);
        do_init(1'b0, 1'b0, REPORT_BYTES);
        do_init(1'b0, 1'b1, REPORT_BYTES);
        do_init(1'b1, 1'b0, 68);
        fill_report(rand_chan(), 8'hbf);
        send_report(REPORT_BYTES);
        fill_report(32'd0, CMD_INIT);
        send_report(REPORT_BYTES);
        fill_report(rand_chan(), 8'h00);
        send_report(REPORT_BYTES);
        tx_done(2);

        // random phases with different idling
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  hold_req = 1'b1; end
                1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
                default: begin send_idle_pct = 20; recv_stall_pct = 20; end
            endcase
            phase_items = 0;
            while (phase_items < 600) random_txn();
        end
        s_valid <= 1'b0;

        wait (pending == 0);
        repeat (400) @(posedge aclk);
        if (errors == 0 && pending == 0)
            $display("tb_ctaphid_u2f_transport: done, clean");
        else
            $display("tb_ctaphid_u2f_transport: done, errors");
        $finish;
    end

endmodule
